// ----- design/mask_iou_batch_meter_top_macros.svh -----
// Assertion shorthands used by the block's top module.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef MASK_IOU_BATCH_METER_TOP_MACROS_SVH
`define MASK_IOU_BATCH_METER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MIB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MIB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mib_pkg.sv -----
package mib_pkg;

  localparam int VAL_W = 16;
  localparam int LBL_W = 8;
  localparam int PIX_W = 21;
  localparam int SUM_W = 25;
  localparam int IMG_W = 9;
  localparam int IOU_W = 17;

  localparam logic [PIX_W-1:0] PIX_CAP = {PIX_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_CAP = {SUM_W{1'b1}};
  localparam logic [IMG_W-1:0] IMG_CAP = {IMG_W{1'b1}};
  localparam logic [IOU_W-1:0] IOU_ONE = {1'b1, {(IOU_W-1){1'b0}}};

  // Divider step counts: the image ratio needs one step per quotient bit,
  // the batch mean one step per bit of the sum.
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic [STEP_W-1:0] IOU_STEPS = STEP_W'(IOU_W);
  localparam logic [STEP_W-1:0] BATCH_STEPS = STEP_W'(SUM_W);

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LABEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_TRIMAP = 2'd2;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [PIX_W-1:0]  rem_init;
    logic [SUM_W-1:0]  num;
    logic [PIX_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- design/mib_if.sv -----
interface mib_pix_if;
  logic                        valid;
  logic                        ready;
  logic [mib_pkg::VAL_W-1:0]   pred_value;
  logic [mib_pkg::VAL_W-1:0]   mask_value;
  logic [mib_pkg::LBL_W-1:0]   trimap_label;
  logic                        last_pixel;
  logic                        last_image;

  modport source (
    output valid, pred_value, mask_value, trimap_label, last_pixel, last_image,
    input  ready
  );
  modport sink (
    input  valid, pred_value, mask_value, trimap_label, last_pixel, last_image,
    output ready
  );
endinterface

interface mib_res_if;
  logic                        valid;
  logic                        ready;
  logic [mib_pkg::IOU_W-1:0]   image_iou;
  logic                        empty_union;
  logic                        batch_done;
  logic [mib_pkg::IOU_W-1:0]   batch_iou;

  modport source (
    output valid, image_iou, empty_union, batch_done, batch_iou,
    input  ready
  );
  modport sink (
    input  valid, image_iou, empty_union, batch_done, batch_iou,
    output ready
  );
endinterface

// ----- design/mib_div.sv -----
module mib_div (
  input  logic              clk,
  input  logic              rst,
  input  mib_pkg::div_req_t req,
  output mib_pkg::div_rsp_t rsp
);

  logic [mib_pkg::PIX_W-1:0]  rem;
  logic [mib_pkg::PIX_W-1:0]  divisor;
  logic [mib_pkg::SUM_W-1:0]  num;
  logic [mib_pkg::SUM_W-1:0]  quot;
  logic [mib_pkg::STEP_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [mib_pkg::PIX_W:0]    shifted;
  logic [mib_pkg::PIX_W:0]    trial;

  // Restoring division, one quotient bit a cycle. The remainder stays below
  // the divisor, so the shifted remainder always fits one extra bit.
  assign shifted = {rem, num[mib_pkg::SUM_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= req.steps;
        rem     <= req.rem_init;
        num     <= req.num;
        divisor <= req.divisor;
        quot    <= '0;
      end else if (busy) begin
        num  <= {num[mib_pkg::SUM_W-2:0], 1'b0};
        rem  <= trial[mib_pkg::PIX_W] ? shifted[mib_pkg::PIX_W-1:0]
                                      : trial[mib_pkg::PIX_W-1:0];
        quot <= {quot[mib_pkg::SUM_W-2:0], ~trial[mib_pkg::PIX_W]};
        cnt  <= cnt - 1'b1;
        if (cnt == mib_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ----- design/mask_iou_batch_meter_top.sv -----
// Binary-mask IoU meter. Pixels are taken one per cycle while the block counts
// union and intersection; a pixel marked last_pixel closes the image and the block
// then stops taking pixels while one shared restoring divider, one bit a cycle,
// works out the image IoU (17 steps) and, when last_image is also set, the batch
// mean (25 steps). An image end therefore holds the input until the division, and
// the batch mean when it also closes the batch, is through, plus any wait for the
// result slot; an image with an empty union skips its division. No other pixel
// holds the input. The single result register lets the next image stream in while
// a result is still waiting to be taken.
`include "mask_iou_batch_meter_top_macros.svh"

module mask_iou_batch_meter_top (
  input  logic                             clk,
  input  logic                             rst,
  mib_pix_if.sink                          pix,
  mib_res_if.source                        res,
  input  logic                             cfg_we,
  input  logic [mib_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mib_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_ISTART = 3'd1;
  localparam logic [2:0] ST_IWAIT  = 3'd2;
  localparam logic [2:0] ST_ACC    = 3'd3;
  localparam logic [2:0] ST_BSTART = 3'd4;
  localparam logic [2:0] ST_BWAIT  = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state;

  logic [mib_pkg::VAL_W-1:0] threshold;
  logic [mib_pkg::LBL_W-1:0] count_label;
  logic                      use_trimap;

  logic [mib_pkg::PIX_W-1:0] icount;
  logic [mib_pkg::PIX_W-1:0] ucount;
  logic [mib_pkg::SUM_W-1:0] iou_sum;
  logic [mib_pkg::IMG_W-1:0] image_count;

  logic [mib_pkg::PIX_W-1:0] icount_next;
  logic [mib_pkg::PIX_W-1:0] ucount_next;

  logic                      last_img;
  logic [mib_pkg::IOU_W-1:0] img_iou;
  logic [mib_pkg::IOU_W-1:0] bat_iou;
  logic                      empty;

  logic                      accept;
  logic                      counted;
  logic                      pred_fg;
  logic                      mask_fg;
  logic [mib_pkg::SUM_W:0]   sum_wide;
  logic [mib_pkg::IOU_W-1:0] quot_clamped;
  logic                      slot_free;

  logic                      res_valid;
  logic [mib_pkg::IOU_W-1:0] res_image_iou;
  logic                      res_empty_union;
  logic                      res_batch_done;
  logic [mib_pkg::IOU_W-1:0] res_batch_iou;

  mib_pkg::div_req_t div_req;
  mib_pkg::div_rsp_t div_rsp;

  mib_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign pix.ready = (state == ST_RUN);
  assign accept    = pix.valid && pix.ready;
  assign slot_free = !res_valid || res.ready;

  assign counted = !use_trimap || (pix.trimap_label == count_label);
  assign pred_fg = pix.pred_value > threshold;
  assign mask_fg = pix.mask_value > threshold;

  // The intersection only grows when the union does or the union is saturated, so it never passes it.
  always_comb begin
    ucount_next = ucount;
    icount_next = icount;
    if (counted && (pred_fg || mask_fg) && (ucount != mib_pkg::PIX_CAP)) begin
      ucount_next = ucount + 1'b1;
    end
    if (counted && pred_fg && mask_fg && (icount != mib_pkg::PIX_CAP)) begin
      icount_next = icount + 1'b1;
    end
  end

  assign quot_clamped = (div_rsp.quot > mib_pkg::SUM_W'(mib_pkg::IOU_ONE))
                        ? mib_pkg::IOU_ONE : div_rsp.quot[mib_pkg::IOU_W-1:0];
  assign sum_wide = {1'b0, iou_sum} + (mib_pkg::SUM_W + 1)'(img_iou);

  // The image quotient is below 2^17, so the upper dividend bits produce no
  // quotient bits and the divider can start from the partial remainder I/2.
  always_comb begin
    div_req = '0;
    if (state == ST_ISTART) begin
      div_req.start    = (ucount != '0);
      div_req.steps    = mib_pkg::IOU_STEPS;
      div_req.rem_init = {1'b0, icount[mib_pkg::PIX_W-1:1]};
      div_req.num      = {icount[0], {(mib_pkg::SUM_W-1){1'b0}}};
      div_req.divisor  = ucount;
    end else if (state == ST_BSTART) begin
      div_req.start    = 1'b1;
      div_req.steps    = mib_pkg::BATCH_STEPS;
      div_req.rem_init = '0;
      div_req.num      = iou_sum;
      div_req.divisor  = {{(mib_pkg::PIX_W-mib_pkg::IMG_W){1'b0}}, image_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= mib_pkg::VAL_W'(32768);
      count_label <= '0;
      use_trimap  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mib_pkg::CFG_THRESHOLD:   threshold   <= cfg_data;
        mib_pkg::CFG_COUNT_LABEL: count_label <= cfg_data[mib_pkg::LBL_W-1:0];
        mib_pkg::CFG_USE_TRIMAP:  use_trimap  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      icount      <= '0;
      ucount      <= '0;
      iou_sum     <= '0;
      image_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      // In ST_OUT the slot is either refilled or still held, so it is cleared
      // here only in the other states.
      if (res_valid && res.ready && (state != ST_OUT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (accept) begin
            icount <= icount_next;
            ucount <= ucount_next;
            if (pix.last_pixel) begin
              last_img <= pix.last_image;
              state    <= ST_ISTART;
            end
          end
        end
        ST_ISTART: begin
          bat_iou <= '0;
          if (ucount == '0) begin
            img_iou <= '0;
            empty   <= 1'b1;
            state   <= ST_ACC;
          end else begin
            empty <= 1'b0;
            state <= ST_IWAIT;
          end
        end
        ST_IWAIT: begin
          if (div_rsp.done) begin
            img_iou <= quot_clamped;
            state   <= ST_ACC;
          end
        end
        ST_ACC: begin
          iou_sum <= (sum_wide > (mib_pkg::SUM_W + 1)'(mib_pkg::SUM_CAP))
                     ? mib_pkg::SUM_CAP : sum_wide[mib_pkg::SUM_W-1:0];
          if (image_count != mib_pkg::IMG_CAP) begin
            image_count <= image_count + 1'b1;
          end
          icount <= '0;
          ucount <= '0;
          state  <= last_img ? ST_BSTART : ST_OUT;
        end
        ST_BSTART: begin
          state <= ST_BWAIT;
        end
        ST_BWAIT: begin
          if (div_rsp.done) begin
            bat_iou     <= quot_clamped;
            iou_sum     <= '0;
            image_count <= '0;
            state       <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            res_valid       <= 1'b1;
            res_image_iou   <= img_iou;
            res_empty_union <= empty;
            res_batch_done  <= last_img;
            res_batch_iou   <= bat_iou;
            state           <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  assign res.valid       = res_valid;
  assign res.image_iou   = res_image_iou;
  assign res.empty_union = res_empty_union;
  assign res.batch_done  = res_batch_done;
  assign res.batch_iou   = res_batch_iou;

  `MIB_ASSERT_NOW(a_inter_le_union, 1'b1, icount <= ucount, "intersection exceeds union")
  `MIB_ASSERT_NOW(a_div_done_state, div_rsp.done, state == ST_IWAIT || state == ST_BWAIT, "divider finished outside a wait state")
  `MIB_ASSERT_NOW(a_batch_count, state == ST_BSTART, image_count != '0, "batch mean started with no images")
  `MIB_ASSERT_NEXT(a_result_load, state == ST_OUT && slot_free, res_valid && state == ST_RUN, "result not loaded when slot was free")
  `MIB_ASSERT_NOW(a_iou_range, state == ST_ACC, img_iou <= mib_pkg::IOU_ONE, "image IoU above one")

endmodule
